// ===== src/jnsv_pkg.sv =====
// Package for the JSON name string validator: state and result types,
// phase codes, status codes and character constants. Depends on nothing.
package jnsv_pkg;

    localparam int unsigned PHASE_W   = 3;
    localparam int unsigned STATUS_W  = 4;
    localparam int unsigned COUNT_W   = 13;
    localparam int unsigned MAXLEN_W  = 12;
    localparam int unsigned ACC_W     = 21;
    localparam int unsigned ESC_W     = 16;

    localparam logic [PHASE_W-1:0] PH_IDLE = 3'd0;
    localparam logic [PHASE_W-1:0] PH_TEXT = 3'd1;
    localparam logic [PHASE_W-1:0] PH_CONT = 3'd2;
    localparam logic [PHASE_W-1:0] PH_ESC  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_HEX  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK         = 4'd0;
    localparam logic [STATUS_W-1:0] ST_DONE       = 4'd1;
    localparam logic [STATUS_W-1:0] ST_IDLE       = 4'd2;
    localparam logic [STATUS_W-1:0] ST_NO_QUOTE   = 4'd3;
    localparam logic [STATUS_W-1:0] ST_CONTROL    = 4'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_LEAD   = 4'd5;
    localparam logic [STATUS_W-1:0] ST_BAD_CONT   = 4'd6;
    localparam logic [STATUS_W-1:0] ST_NONSCALAR  = 4'd7;
    localparam logic [STATUS_W-1:0] ST_BAD_ESCAPE = 4'd8;
    localparam logic [STATUS_W-1:0] ST_BAD_HEX    = 4'd9;
    localparam logic [STATUS_W-1:0] ST_BAD_UVAL   = 4'd10;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 4'd11;
    localparam logic [STATUS_W-1:0] ST_BAD_NAME   = 4'd12;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_U         = 8'h75;

    localparam logic [MAXLEN_W-1:0] MAX_NAME_RESET = 12'd512;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [1:0]         continuations_left;
        logic [ACC_W-1:0]   scalar_accumulator;
        logic [1:0]         sequence_class;
        logic [2:0]         hex_digits_left;
        logic [ESC_W-1:0]   escape_code;
        logic [COUNT_W-1:0] byte_count;
        logic               forbidden_seen;
    } t_state;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [7:0]          out_byte;
        logic                out_valid;
        logic [COUNT_W-1:0]  name_length;
    } t_result;

endpackage

// ===== src/jnsv_in_if.sv =====
// Input channel of the JSON name string validator: one raw byte per word.
// Depends on nothing outside this file.
interface jnsv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       start_req;

    modport source (output valid, output in_byte, output start_req, input ready);
    modport sink   (input valid, input in_byte, input start_req, output ready);
endinterface

// ===== src/jnsv_out_if.sv =====
// Result channel of the JSON name string validator: one status word per byte.
// Depends on nothing outside this file.
interface jnsv_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [7:0]  out_byte;
    logic        out_valid;
    logic [12:0] name_length;

    modport source (output valid, output status, output out_byte, output out_valid,
                    output name_length, input ready);
    modport sink   (input valid, input status, input out_byte, input out_valid,
                    input name_length, output ready);
endinterface

// ===== src/json_name_string_validator.sv =====
// Top level of the JSON name string validator: input register, decode step
// and result register. Depends on jnsv_pkg, jnsv_in_if, jnsv_out_if, jnsv_step.
//
// Usage: each input word carries one raw byte of a JSON string and a start
// flag. A start word must hold the opening quote and begins a new string,
// abandoning any string in progress. Every input word yields exactly one
// result word with a status, the decoded byte it appended (if any), a flag
// telling whether a byte was appended, and the running decoded length.
// After an error or the closing quote the block answers "idle" until the
// next start word.
// An accepted word waits in the input register, is decoded by the step and
// enters the result register when that is free or being emptied. Throughput
// is one word per cycle while results are taken; the decode state is updated
// in the same cycle that a word enters the result register. When the receiver
// stalls, the result register holds its word and the input register can still
// take one more word, after which ready drops. The length ceiling is written
// via i_cfg_we/i_cfg_data; the user must write it only while no word is in
// flight, as the block does not enforce it. Reset clears both registers' valid
// flags, the decode state (idle, empty name) and sets the ceiling to 512 bytes.
module json_name_string_validator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [jnsv_pkg::MAXLEN_W-1:0] i_cfg_data,
    jnsv_in_if.sink                       i_in,
    jnsv_out_if.source                    o_out
);

    logic [jnsv_pkg::MAXLEN_W-1:0] r_max_name_bytes;
    jnsv_pkg::t_state              r_state;
    jnsv_pkg::t_state              n_state;
    jnsv_pkg::t_result             r_result;
    jnsv_pkg::t_result             n_result;
    logic                          r_in_valid;
    logic [7:0]                    r_in_byte;
    logic                          r_in_start;
    logic                          r_out_valid;
    logic                          advance;
    logic                          in_take;

    // A word leaves the input register when the result register is free
    // or is being emptied in this cycle.
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_take    = i_in.valid && i_in.ready;

    jnsv_step u_step (
        .i_state          (r_state),
        .i_byte           (r_in_byte),
        .i_start          (r_in_start),
        .i_max_name_bytes (r_max_name_bytes),
        .o_state          (n_state),
        .o_result         (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_name_bytes <= jnsv_pkg::MAX_NAME_RESET;
        end else if (i_cfg_we) begin
            r_max_name_bytes <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte  <= i_in.in_byte;
            r_in_start <= i_in.start_req;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_result.status;
    assign o_out.out_byte    = r_result.out_byte;
    assign o_out.out_valid   = r_result.out_valid;
    assign o_out.name_length = r_result.name_length;

endmodule

// ===== src/jnsv_step.sv =====
// Per-byte decode logic of the validator: next state and result word from the
// current state and one input byte. Depends on jnsv_pkg.
module jnsv_step (
    input  jnsv_pkg::t_state              i_state,
    input  logic [7:0]                    i_byte,
    input  logic                          i_start,
    input  logic [jnsv_pkg::MAXLEN_W-1:0] i_max_name_bytes,
    output jnsv_pkg::t_state              o_state,
    output jnsv_pkg::t_result             o_result
);

    always_comb begin
        jnsv_pkg::t_state           n;
        logic [jnsv_pkg::STATUS_W-1:0] status;
        logic [7:0]                 res_byte;
        logic                       res_valid;
        logic                       app_en;
        logic                       app_complete;
        logic [7:0]                 app_byte;
        logic [jnsv_pkg::COUNT_W:0] next_count;
        logic [jnsv_pkg::ACC_W-1:0] acc_new;
        logic [1:0]                 cl_new;
        logic [jnsv_pkg::ACC_W-1:0] minimum;
        logic [jnsv_pkg::ESC_W-1:0] esc_new;
        logic [2:0]                 hl_new;
        logic [3:0]                 hex_v;
        logic                       hex_ok;
        logic [7:0]                 esc_d;
        logic                       esc_ok;

        n            = i_state;
        status       = jnsv_pkg::ST_OK;
        res_byte     = 8'd0;
        res_valid    = 1'b0;
        app_en       = 1'b0;
        app_complete = 1'b0;
        app_byte     = 8'd0;
        acc_new      = {i_state.scalar_accumulator[jnsv_pkg::ACC_W-7:0], i_byte[5:0]};
        cl_new       = i_state.continuations_left - 2'd1;
        esc_new      = '0;
        hl_new       = i_state.hex_digits_left - 3'd1;
        hex_v        = 4'd0;
        hex_ok       = 1'b0;
        esc_d        = 8'd0;
        esc_ok       = 1'b1;

        case (i_state.sequence_class)
            2'd1:    minimum = 21'h00080;
            2'd2:    minimum = 21'h00800;
            default: minimum = 21'h10000;
        endcase

        case (i_byte) inside
            [8'h30:8'h39]: begin
                hex_v  = i_byte[3:0];
                hex_ok = 1'b1;
            end
            [8'h61:8'h66]: begin
                hex_v  = i_byte[3:0] + 4'd9;
                hex_ok = 1'b1;
            end
            default: begin
                hex_v  = 4'd0;
                hex_ok = 1'b0;
            end
        endcase
        esc_new = {i_state.escape_code[jnsv_pkg::ESC_W-5:0], hex_v};

        case (i_byte)
            8'h22:   esc_d = 8'h22;
            8'h5C:   esc_d = 8'h5C;
            8'h62:   esc_d = 8'h08;
            8'h66:   esc_d = 8'h0C;
            8'h6E:   esc_d = 8'h0A;
            8'h72:   esc_d = 8'h0D;
            8'h74:   esc_d = 8'h09;
            default: esc_ok = 1'b0;
        endcase

        if (i_start) begin
            n.continuations_left = '0;
            n.scalar_accumulator = '0;
            n.sequence_class     = '0;
            n.hex_digits_left    = '0;
            n.escape_code        = '0;
            n.byte_count         = '0;
            n.forbidden_seen     = 1'b0;
            if (i_byte == jnsv_pkg::CH_QUOTE) begin
                n.phase = jnsv_pkg::PH_TEXT;
            end else begin
                n.phase = jnsv_pkg::PH_IDLE;
                status  = jnsv_pkg::ST_NO_QUOTE;
            end
        end else begin
            case (i_state.phase)
                jnsv_pkg::PH_TEXT: begin
                    if (i_byte == jnsv_pkg::CH_QUOTE) begin
                        status  = (i_state.byte_count == '0 || i_state.forbidden_seen)
                                  ? jnsv_pkg::ST_BAD_NAME : jnsv_pkg::ST_DONE;
                        n.phase = jnsv_pkg::PH_IDLE;
                    end else if (i_byte < jnsv_pkg::CH_SPACE) begin
                        status  = jnsv_pkg::ST_CONTROL;
                        n.phase = jnsv_pkg::PH_IDLE;
                    end else if (i_byte == jnsv_pkg::CH_BACKSLASH) begin
                        n.phase = jnsv_pkg::PH_ESC;
                    end else if (!i_byte[7]) begin
                        app_en       = 1'b1;
                        app_complete = 1'b1;
                        app_byte     = i_byte;
                    end else if (i_byte[7:5] == 3'b110) begin
                        n.continuations_left = 2'd1;
                        n.sequence_class     = 2'd1;
                        n.scalar_accumulator = {16'd0, i_byte[4:0]};
                        n.phase              = jnsv_pkg::PH_CONT;
                        app_en               = 1'b1;
                        app_byte             = i_byte;
                    end else if (i_byte[7:4] == 4'b1110) begin
                        n.continuations_left = 2'd2;
                        n.sequence_class     = 2'd2;
                        n.scalar_accumulator = {17'd0, i_byte[3:0]};
                        n.phase              = jnsv_pkg::PH_CONT;
                        app_en               = 1'b1;
                        app_byte             = i_byte;
                    end else if (i_byte[7:3] == 5'b11110) begin
                        n.continuations_left = 2'd3;
                        n.sequence_class     = 2'd3;
                        n.scalar_accumulator = {18'd0, i_byte[2:0]};
                        n.phase              = jnsv_pkg::PH_CONT;
                        app_en               = 1'b1;
                        app_byte             = i_byte;
                    end else begin
                        status  = jnsv_pkg::ST_BAD_LEAD;
                        n.phase = jnsv_pkg::PH_IDLE;
                    end
                end
                jnsv_pkg::PH_CONT: begin
                    if (i_byte[7:6] != 2'b10) begin
                        status  = jnsv_pkg::ST_BAD_CONT;
                        n.phase = jnsv_pkg::PH_IDLE;
                    end else begin
                        n.scalar_accumulator = acc_new;
                        n.continuations_left = cl_new;
                        app_byte             = i_byte;
                        if (cl_new != 2'd0) begin
                            app_en = 1'b1;
                        end else if (acc_new < minimum || acc_new > 21'h10FFFF ||
                                     (acc_new >= 21'h0D800 && acc_new <= 21'h0DFFF)) begin
                            status  = jnsv_pkg::ST_NONSCALAR;
                            n.phase = jnsv_pkg::PH_IDLE;
                        end else begin
                            n.phase      = jnsv_pkg::PH_TEXT;
                            app_en       = 1'b1;
                            app_complete = 1'b1;
                        end
                    end
                end
                jnsv_pkg::PH_ESC: begin
                    if (i_byte == jnsv_pkg::CH_U) begin
                        n.hex_digits_left = 3'd4;
                        n.escape_code     = '0;
                        n.phase           = jnsv_pkg::PH_HEX;
                    end else if (!esc_ok) begin
                        status  = jnsv_pkg::ST_BAD_ESCAPE;
                        n.phase = jnsv_pkg::PH_IDLE;
                    end else begin
                        n.phase      = jnsv_pkg::PH_TEXT;
                        app_en       = 1'b1;
                        app_complete = 1'b1;
                        app_byte     = esc_d;
                    end
                end
                jnsv_pkg::PH_HEX: begin
                    if (!hex_ok) begin
                        status  = jnsv_pkg::ST_BAD_HEX;
                        n.phase = jnsv_pkg::PH_IDLE;
                    end else begin
                        n.escape_code     = esc_new;
                        n.hex_digits_left = hl_new;
                        if (hl_new == 3'd0) begin
                            if (esc_new > 16'h007F || esc_new == 16'h0000) begin
                                status  = jnsv_pkg::ST_BAD_UVAL;
                                n.phase = jnsv_pkg::PH_IDLE;
                            end else begin
                                n.phase      = jnsv_pkg::PH_TEXT;
                                app_en       = 1'b1;
                                app_complete = 1'b1;
                                app_byte     = esc_new[7:0];
                            end
                        end
                    end
                end
                default: begin
                    n.phase = jnsv_pkg::PH_IDLE;
                    status  = jnsv_pkg::ST_IDLE;
                end
            endcase
        end

        // Append one decoded byte; the ceiling is checked only when a
        // character completes, so raw lead and middle bytes always land.
        next_count = {1'b0, i_state.byte_count} + 14'd1;
        if (app_en) begin
            if (app_complete && next_count > {2'b00, i_max_name_bytes}) begin
                status  = jnsv_pkg::ST_TOO_LONG;
                n.phase = jnsv_pkg::PH_IDLE;
            end else begin
                n.byte_count = next_count[jnsv_pkg::COUNT_W-1:0];
                if (app_byte == jnsv_pkg::CH_SLASH || app_byte == jnsv_pkg::CH_BACKSLASH ||
                    app_byte == jnsv_pkg::CH_NUL) begin
                    n.forbidden_seen = 1'b1;
                end
                res_byte  = app_byte;
                res_valid = 1'b1;
            end
        end

        o_state              = n;
        o_result.status      = status;
        o_result.out_byte    = res_byte;
        o_result.out_valid   = res_valid;
        o_result.name_length = n.byte_count;
    end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for json_name_string_validator: raw JSON name bytes in, one status
// word out per byte, checked against a predictor of the decode rules kept in a scoreboard.
// Depends on jnsv_pkg, jnsv_in_if, jnsv_out_if and the validator RTL.

import jnsv_pkg::*;

// The scoreboard predicts the validator word by word. It keeps its own copy of the decode
// state and of the length ceiling, and queues one expected result word per accepted input.
class name_scoreboard;
    logic [MAXLEN_W-1:0] ceiling;
    t_state              st;
    t_result             expected_q[$];
    int unsigned         mismatches;
    int unsigned         checked;
    int unsigned         words_noted;
    bit                  status_seen[16];

    function new();
        ceiling     = MAX_NAME_RESET;
        st          = '0;
        mismatches  = 0;
        checked     = 0;
        words_noted = 0;
        foreach (status_seen[i]) status_seen[i] = 1'b0;
    endfunction

    function void set_ceiling(logic [MAXLEN_W-1:0] value);
        ceiling = value;
    endfunction

    // An error appends nothing and sends the decoder back to idle.
    function void fail_item(inout t_result r, input logic [STATUS_W-1:0] code);
        r.status    = code;
        r.out_byte  = '0;
        r.out_valid = 1'b0;
        st.phase    = PH_IDLE;
    endfunction

    // Appends one decoded byte. The ceiling is only checked when a character completes,
    // so the leading bytes of a UTF-8 sequence may run past it.
    function void append_byte(inout t_result r, input logic [7:0] b, input logic complete);
        logic [COUNT_W:0] next_count;
        next_count = {1'b0, st.byte_count} + 14'd1;
        if (complete && next_count > {2'b00, ceiling}) begin
            fail_item(r, ST_TOO_LONG);
            return;
        end
        st.byte_count = next_count[COUNT_W-1:0];
        if (b == CH_SLASH || b == CH_BACKSLASH || b == CH_NUL) st.forbidden_seen = 1'b1;
        r.out_byte  = b;
        r.out_valid = 1'b1;
    endfunction

    function t_result predict_word(logic [7:0] b, logic s);
        t_result          r;
        logic [1:0]       left;
        logic [ACC_W-1:0] acc;
        logic [ACC_W-1:0] lowest;
        logic [8:0]       decoded;
        int               digit;
        r = '0;
        if (s) begin
            // A start always abandons whatever string was in progress.
            st.continuations_left = '0;
            st.scalar_accumulator = '0;
            st.sequence_class     = '0;
            st.hex_digits_left    = '0;
            st.escape_code        = '0;
            st.byte_count         = '0;
            st.forbidden_seen     = 1'b0;
            if (b == CH_QUOTE) st.phase = PH_TEXT;
            else fail_item(r, ST_NO_QUOTE);
        end else begin
            case (st.phase)
                PH_TEXT: begin
                    if (b == CH_QUOTE) begin
                        r.status = (st.byte_count == 0 || st.forbidden_seen) ? ST_BAD_NAME
                                                                             : ST_DONE;
                        st.phase = PH_IDLE;
                    end else if (b < CH_SPACE) begin
                        fail_item(r, ST_CONTROL);
                    end else if (b == CH_BACKSLASH) begin
                        st.phase = PH_ESC;
                    end else if (b < 8'h80) begin
                        append_byte(r, b, 1'b1);
                    end else begin
                        left = '0;
                        acc  = '0;
                        if (b[7:5] == 3'b110) begin
                            left = 2'd1;
                            acc  = ACC_W'(b[4:0]);
                        end else if (b[7:4] == 4'b1110) begin
                            left = 2'd2;
                            acc  = ACC_W'(b[3:0]);
                        end else if (b[7:3] == 5'b11110) begin
                            left = 2'd3;
                            acc  = ACC_W'(b[2:0]);
                        end
                        if (left == 0) begin
                            fail_item(r, ST_BAD_LEAD);
                        end else begin
                            st.continuations_left = left;
                            st.sequence_class     = left;
                            st.scalar_accumulator = acc;
                            append_byte(r, b, 1'b0);
                            st.phase = PH_CONT;
                        end
                    end
                end
                PH_CONT: begin
                    if (b[7:6] != 2'b10) begin
                        fail_item(r, ST_BAD_CONT);
                    end else begin
                        st.scalar_accumulator = {st.scalar_accumulator[ACC_W-7:0], b[5:0]};
                        st.continuations_left = st.continuations_left - 1'b1;
                        if (st.continuations_left != 0) begin
                            append_byte(r, b, 1'b0);
                        end else begin
                            lowest = (st.sequence_class == 2'd1) ? 21'h80
                                   : (st.sequence_class == 2'd2) ? 21'h800 : 21'h10000;
                            acc = st.scalar_accumulator;
                            if (acc < lowest || acc > 21'h10FFFF ||
                                (acc >= 21'hD800 && acc <= 21'hDFFF)) begin
                                fail_item(r, ST_NONSCALAR);
                            end else begin
                                st.phase = PH_TEXT;
                                append_byte(r, b, 1'b1);
                            end
                        end
                    end
                end
                PH_ESC: begin
                    // Bit 8 set means the letter after the backslash is not a known escape.
                    decoded = 9'h100;
                    case (b)
                        CH_QUOTE, CH_BACKSLASH: decoded = {1'b0, b};
                        "b":                    decoded = 9'h008;
                        "f":                    decoded = 9'h00C;
                        "n":                    decoded = 9'h00A;
                        "r":                    decoded = 9'h00D;
                        "t":                    decoded = 9'h009;
                        default:                ;
                    endcase
                    if (b == CH_U) begin
                        st.hex_digits_left = 3'd4;
                        st.escape_code     = '0;
                        st.phase           = PH_HEX;
                    end else if (decoded[8]) begin
                        fail_item(r, ST_BAD_ESCAPE);
                    end else begin
                        st.phase = PH_TEXT;
                        append_byte(r, decoded[7:0], 1'b1);
                    end
                end
                PH_HEX: begin
                    if (b >= "0" && b <= "9") digit = int'(b) - int'("0");
                    else if (b >= "a" && b <= "f") digit = int'(b) - int'("a") + 10;
                    else digit = -1;
                    if (digit < 0) begin
                        fail_item(r, ST_BAD_HEX);
                    end else begin
                        st.escape_code     = {st.escape_code[ESC_W-5:0], digit[3:0]};
                        st.hex_digits_left = st.hex_digits_left - 1'b1;
                        if (st.hex_digits_left == 0) begin
                            if (st.escape_code > 16'h7F || st.escape_code == 0) begin
                                fail_item(r, ST_BAD_UVAL);
                            end else begin
                                st.phase = PH_TEXT;
                                append_byte(r, st.escape_code[7:0], 1'b1);
                            end
                        end
                    end
                end
                default: begin
                    st.phase = PH_IDLE;
                    r.status = ST_IDLE;
                end
            endcase
        end
        r.name_length = st.byte_count;
        return r;
    endfunction

    function void note_word(logic [7:0] b, logic s);
        t_result r;
        r = predict_word(b, s);
        status_seen[r.status] = 1'b1;
        words_noted++;
        expected_q.insert(expected_q.size(), r);
    endfunction

    task report(string msg);
        $display("MISMATCH at result %0d: %s", checked, msg);
        mismatches++;
    endtask

    task check_result(t_result got);
        t_result want;
        checked++;
        if (expected_q.size() == 0) begin
            report($sformatf("result with no word pending, status %0d", got.status));
            return;
        end
        want = expected_q.pop_front();
        if (got.status !== want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.out_byte !== want.out_byte)
            report($sformatf("out_byte %02h, expected %02h", got.out_byte, want.out_byte));
        if (got.out_valid !== want.out_valid)
            report($sformatf("out_valid %0b, expected %0b", got.out_valid, want.out_valid));
        if (got.name_length !== want.name_length)
            report($sformatf("name_length %0d, expected %0d",
                             got.name_length, want.name_length));
    endtask
endclass

module tb;
    // The run stops with a failure if it is still going after this many cycles. A correct
    // run stays below this limit, even with the heaviest idling and the long hold-off.
    localparam int unsigned CYCLE_LIMIT  = 400000;
    // Number of name words in the random part, spread over the ceiling phases.
    localparam int unsigned RANDOM_WORDS = 850;
    localparam int unsigned N_PHASES     = 6;
    // Length of the single long receiver hold-off, in cycles.
    localparam int unsigned HOLD_CYCLES  = 200;
    // A word passes two registers; drain() still waits this long after the last result.
    localparam int unsigned DRAIN_CYCLES = 4;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [MAXLEN_W-1:0] i_cfg_data;

    jnsv_in_if  in_if ();
    jnsv_out_if out_if ();

    json_name_string_validator i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    name_scoreboard sb;

    int unsigned cycles;
    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    int unsigned name_words;
    int unsigned names_sent;
    int unsigned ceilings_used;
    // The main process asks for a receiver hold-off by bumping hold_requests; the receiver
    // process owns the countdown and keeps its own tally of requests served.
    int unsigned hold_requests;
    int unsigned hold_served;
    int unsigned hold_left;
    bit          noisy_name;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver: random back-pressure at the falling edge, or a long hold-off when asked.
    initial begin
        out_if.ready = 1'b0;
        hold_served  = 0;
        hold_left    = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = HOLD_CYCLES - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Monitor and watchdog. Everything is sampled at the rising edge, while the inputs were
    // set up at the falling edge before, so the order of events within the edge is irrelevant.
    // A result can never leave the block at the edge its input word enters, so checking the
    // output before noting the input is safe.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results pending",
                     cycles, sb.expected_q.size());
            $display("Some tests failed");
            $finish;
        end else if (i_rst_n) begin
            if (out_if.valid === 1'b1 && out_if.ready)
                sb.check_result(t_result'({out_if.status, out_if.out_byte,
                                           out_if.out_valid, out_if.name_length}));
            if (in_if.valid && in_if.ready === 1'b1)
                sb.note_word(in_if.in_byte, in_if.start_req);
        end
    end

    // Offers one word and returns at the edge that accepts it. Valid stays high into the next
    // call, so back-to-back words need no gap with valid low in between.
    task automatic send_word(input logic [7:0] b, input logic s);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.in_byte   <= b;
        in_if.start_req <= s;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
    endtask

    // Drops valid, waits for every result to come back and lets the pipeline settle.
    task automatic drain();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes the length ceiling while the block is idle and mirrors it in the scoreboard.
    task automatic write_ceiling(input logic [MAXLEN_W-1:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        sb.set_ceiling(value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        ceilings_used++;
    endtask

    // Directed sequence of up to twelve bytes, right-aligned; the first one carries the start.
    task automatic send_seq(input logic [95:0] seq, input int n);
        for (int i = 0; i < n; i++)
            send_word(seq[8*(n-1-i) +: 8], i == 0);
    endtask

    // One byte of a random name. In a noisy name a few bytes are replaced by garbage or
    // carry a stray start, which abandons the string in progress.
    task automatic put(input logic [7:0] b, input logic s);
        int unsigned roll;
        roll = $urandom_range(99);
        if (noisy_name && roll < 8) b = 8'($urandom_range(255));
        else if (noisy_name && roll < 10) s = 1'b1;
        name_words++;
        send_word(b, s);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 10) ? 8'("0" + n) : 8'("a" + n - 10);
    endfunction

    // Encodes a scalar in n UTF-8 bytes without any range check, so that overlong forms,
    // surrogates and values above the last plane come out just as easily as legal ones.
    task automatic put_scalar(input logic [20:0] code, input int n);
        logic [20:0] part;
        case (n)
            2:       put({3'b110, code[10:6]}, 1'b0);
            3:       put({4'b1110, code[15:12]}, 1'b0);
            default: put({5'b11110, code[20:18]}, 1'b0);
        endcase
        for (int k = n - 2; k >= 0; k--) begin
            part = code >> (6 * k);
            put({2'b10, part[5:0]}, 1'b0);
        end
    endtask

    // One \u escape with four digits; with bad_digits some digits are uppercase or not hex.
    task automatic put_uescape(input logic [15:0] value, input bit bad_digits);
        logic [7:0] c;
        put(CH_BACKSLASH, 1'b0);
        put(CH_U, 1'b0);
        for (int k = 3; k >= 0; k--) begin
            c = hex_char(value[4*k +: 4]);
            if (bad_digits && $urandom_range(3) == 0)
                c = ($urandom_range(1) == 1) ? 8'("A" + $urandom_range(5)) : 8'("g");
            put(c, 1'b0);
        end
    endtask

    // A random name: mostly well-formed characters of every kind, sometimes with broken
    // characters, garbage bytes, a missing closing quote or idle words after it.
    task automatic send_random_name();
        int unsigned n_chars;
        int unsigned kind;
        int          n;
        logic [20:0] code;
        logic [7:0]  c;
        noisy_name = ($urandom_range(99) < 25);
        n_chars    = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 10);
        names_sent++;
        put(CH_QUOTE, 1'b1);
        for (int i = 0; i < n_chars; i++) begin
            kind = $urandom_range(99);
            if (noisy_name && $urandom_range(4) == 0) begin
                case ($urandom_range(7))
                    0: put(8'($urandom_range(8'h1F)), 1'b0);
                    1: put(($urandom_range(1) == 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                                    : 8'($urandom_range(8'hF8, 8'hFF)), 1'b0);
                    2: begin
                        // Overlong: a scalar below the floor of its sequence length.
                        n    = $urandom_range(2, 4);
                        code = 21'($urandom_range((n == 2) ? 32'h7F
                                                 : (n == 3) ? 32'h7FF : 32'hFFFF));
                        put_scalar(code, n);
                    end
                    3: put_scalar(21'($urandom_range(32'hD800, 32'hDFFF)), 3);
                    4: put_scalar(21'($urandom_range(32'h110000, 32'h1FFFFF)), 4);
                    5: begin
                        put(CH_BACKSLASH, 1'b0);
                        put(8'($urandom_range(255)), 1'b0);
                    end
                    6: put_uescape(16'($urandom_range(16'hFFFF)), 1'b1);
                    default: begin
                        // Sequence cut short by a plain character.
                        put(8'hC3, 1'b0);
                        put("a", 1'b0);
                    end
                endcase
            end else if (kind < 50) begin
                c = 8'($urandom_range(8'h20, 8'h7E));
                if (c == CH_QUOTE || c == CH_BACKSLASH) c = "_";
                put(c, 1'b0);
            end else if (kind < 60) begin
                put(CH_BACKSLASH, 1'b0);
                case ($urandom_range(6))
                    0:       put(CH_QUOTE, 1'b0);
                    1:       put(CH_BACKSLASH, 1'b0);
                    2:       put("b", 1'b0);
                    3:       put("f", 1'b0);
                    4:       put("n", 1'b0);
                    5:       put("r", 1'b0);
                    default: put("t", 1'b0);
                endcase
            end else if (kind < 70) begin
                put_uescape(16'($urandom_range(1, 16'h7F)), 1'b0);
            end else if (kind < 80) begin
                put_scalar(21'($urandom_range(32'h80, 32'h7FF)), 2);
            end else if (kind < 90) begin
                code = 21'($urandom_range(32'h800, 32'hFFFF));
                if (code >= 21'hD800 && code <= 21'hDFFF) code = code ^ 21'h2000;
                put_scalar(code, 3);
            end else begin
                put_scalar(21'($urandom_range(32'h10000, 32'h10FFFF)), 4);
            end
        end
        if (!(noisy_name && $urandom_range(9) == 0)) put(CH_QUOTE, 1'b0);
        // Words with no start while idle are only ignored, so they do not count as name words.
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 3)) send_word(8'($urandom_range(255)), 1'b0);
    endtask

    // A clean name of n_plain letters, optionally followed by a four-byte character whose
    // leading bytes still get appended before the ceiling check on its last byte.
    task automatic send_long_name(input int n_plain, input bit utf8_tail);
        noisy_name = 1'b0;
        names_sent++;
        send_word(CH_QUOTE, 1'b1);
        repeat (n_plain) send_word("a", 1'b0);
        if (utf8_tail) put_scalar(21'h10000, 4);
        else send_word(CH_QUOTE, 1'b0);
    endtask

    initial begin
        logic [MAXLEN_W-1:0] phase_ceiling[N_PHASES];
        sb              = new();
        cycles          = 0;
        name_words      = 0;
        names_sent      = 0;
        ceilings_used   = 1;
        hold_requests   = 0;
        noisy_name      = 1'b0;
        src_idle_pct    = 29;
        sink_idle_pct   = 54;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_data      = '0;
        in_if.valid     = 1'b0;
        in_if.in_byte   = '0;
        in_if.start_req = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset ceiling of 512 bytes.
        send_word("A", 1'b0);                                  // idle before any start
        send_seq(8'hFF, 1);                                    // start without a quote
        send_seq({CH_QUOTE, CH_QUOTE}, 2);                     // empty name
        send_seq({CH_QUOTE, 8'h20, 8'h7E, 8'h61, CH_QUOTE}, 5);
        send_seq({CH_QUOTE, 8'h1F}, 2);                        // control byte
        send_seq({CH_QUOTE, 8'h80}, 2);                        // continuation as lead
        send_seq({CH_QUOTE, 8'hC3, CH_QUOTE}, 3);              // quote inside a sequence
        send_seq({CH_QUOTE, 8'hC1, 8'hBF}, 3);                 // overlong two-byte form
        send_seq({CH_QUOTE, 8'hED, 8'hA0, 8'h80}, 4);          // surrogate
        send_seq({CH_QUOTE, 8'hF4, 8'h90, 8'h80, 8'h80}, 5);   // above the last plane
        send_seq({CH_QUOTE, 8'hC3, 8'hA9, 8'hF0, 8'h9F, 8'h98, 8'h80, CH_QUOTE}, 8);
        send_seq({CH_QUOTE, 8'h5C, 8'h22, 8'h5C, 8'h62, 8'h5C, 8'h66,
                  8'h5C, 8'h6E, 8'h5C, 8'h72, CH_QUOTE}, 12);
        send_seq({CH_QUOTE, 8'h5C, 8'h74, 8'h5C, 8'h5C, CH_QUOTE}, 6);  // holds a backslash
        send_seq({CH_QUOTE, 8'h5C, CH_SLASH}, 3);              // escaped slash is not allowed
        send_seq({CH_QUOTE, 8'h5C, CH_U, "007f", CH_QUOTE}, 8);
        send_seq({CH_QUOTE, 8'h5C, CH_U, "0000"}, 7);          // \u value of zero
        send_seq({CH_QUOTE, 8'h5C, CH_U, "0080"}, 7);          // \u value past ASCII
        send_seq({CH_QUOTE, 8'h5C, CH_U, "004A"}, 7);          // uppercase hex digit
        send_seq({CH_QUOTE, 8'h61, CH_SLASH, CH_QUOTE}, 4);    // holds a slash
        send_seq({CH_QUOTE, 8'h61, 8'h62}, 3);                 // abandoned by the next start
        send_seq({CH_QUOTE, 8'h63, CH_QUOTE}, 3);
        send_word(8'h00, 1'b0);                                // idle after the closing quote

        // A ceiling of zero makes any character too long; one byte only fits one character.
        write_ceiling('0);
        send_seq({CH_QUOTE, 8'h61}, 2);
        send_seq({CH_QUOTE, CH_QUOTE}, 2);
        write_ceiling(12'd1);
        send_seq({CH_QUOTE, 8'h61, CH_QUOTE}, 3);
        send_seq({CH_QUOTE, 8'h61, 8'h62}, 3);
        send_seq({CH_QUOTE, 8'hC3, 8'hA9}, 3);

        // Random part. The ceiling changes between phases, the small ones so that random
        // names often run into them. Idling moves from the sender-light mix to the
        // receiver-light mix and finally to none at all.
        phase_ceiling = '{12'd8, 12'd1, 12'd4095, 12'd3,
                          12'($urandom_range(1, 4095)), 12'd30};
        for (int p = 0; p < N_PHASES; p++) begin
            write_ceiling(phase_ceiling[p]);
            if (p == N_PHASES - 1) begin
                send_long_name(30, 1'b0);       // exactly at the ceiling of 30 bytes
                send_long_name(30, 1'b1);       // one character past it
            end
            while (name_words < (p + 1) * RANDOM_WORDS / N_PHASES) begin
                if (name_words < RANDOM_WORDS / 3) begin
                    src_idle_pct  = 29;
                    sink_idle_pct = 54;
                end else if (name_words < 2 * RANDOM_WORDS / 3) begin
                    src_idle_pct  = 54;
                    sink_idle_pct = 29;
                end else begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
                // One long hold-off while the sender keeps offering, so both registers fill
                // and the input side stalls.
                if (p == 0 && hold_requests == 0 && name_words > 60) hold_requests++;
                send_random_name();
            end
        end

        drain();
        repeat (2 * DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d result words for %0d input words in %0d names, %0d cycles.",
                 sb.checked, sb.words_noted, names_sent, cycles);
        $display("Used %0d length ceilings and saw %0d distinct status codes.", ceilings_used,
                 sb.status_seen.sum() with (int'(item)));
        if (sb.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
